// ----- rtl/itrd_pkg.sv -----
// Shared types, constants and helpers for the integer-to-radix-digits unit.
// No dependencies; imported by the divider, the top level and the checker.
package itrd_pkg;

  localparam logic [6:0] CH_ZERO       = 7'h30;
  localparam logic [6:0] CH_LETTER     = 7'h61;
  localparam logic [6:0] CH_MINUS      = 7'h2d;
  localparam logic [3:0] DECIMAL_LIMIT = 4'd10;
  localparam logic [4:0] RADIX_RESET   = 5'd10;
  localparam logic [4:0] RADIX_MIN     = 5'd2;
  localparam logic [4:0] RADIX_MAX     = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_DIGITS
  } itrd_state_e;

  // Commands from the sequencer to the serial divider.
  typedef struct packed {
    logic load;   // capture a new magnitude
    logic start;  // begin one division pass
  } div_ctrl_t;

  // Status from the serial divider.
  typedef struct packed {
    logic       done;   // pass finished, digit and flag valid
    logic       qnz;    // quotient of the finished pass is nonzero
    logic [3:0] digit;  // remainder of the finished pass
  } div_stat_t;

  function automatic logic [4:0] effective_radix(input logic [4:0] r);
    logic [4:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] res;
    if (d < DECIMAL_LIMIT) begin
      res = CH_ZERO + {3'b000, d};
    end else begin
      res = CH_LETTER + {3'b000, d - DECIMAL_LIMIT};
    end
    return res;
  endfunction

endpackage

// ----- rtl/itrd_divider.sv -----
// Bit-serial restoring divider: divides a magnitude by the radix, one
// quotient bit per cycle, leaving the quotient in place. Uses itrd_pkg.
module itrd_divider #(
  parameter int W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itrd_pkg::div_ctrl_t  ctrl_i,
  input  logic [W-1:0]         mag_i,
  input  logic [4:0]           radix_i,
  output itrd_pkg::div_stat_t  stat_o
);
  import itrd_pkg::*;

  localparam int BW = $clog2(W + 1);

  logic [W-1:0]  mag_q, mag_d;
  logic [3:0]    rem_q, rem_d;
  logic          qnz_q, qnz_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [BW-1:0] bcnt_q, bcnt_d;

  logic [4:0] trial;
  logic [4:0] trial_sub;
  logic       qbit;

  assign trial     = {rem_q, mag_q[W-1]};
  assign qbit      = (trial >= radix_i);
  assign trial_sub = trial - radix_i;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    qnz_d  = qnz_q;
    run_d  = run_q;
    done_d = 1'b0;
    bcnt_d = bcnt_q;
    if (ctrl_i.load) begin
      mag_d = mag_i;
    end
    if (ctrl_i.start) begin
      rem_d  = 4'd0;
      qnz_d  = 1'b0;
      run_d  = 1'b1;
      bcnt_d = BW'(W);
    end else if (run_q) begin
      // shift dividend out of the top, quotient bit in at the bottom
      mag_d  = {mag_q[W-2:0], qbit};
      rem_d  = qbit ? trial_sub[3:0] : trial[3:0];
      qnz_d  = qnz_q | qbit;
      bcnt_d = bcnt_q - BW'(1);
      if (bcnt_q == BW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bcnt_q <= '0;
      qnz_q  <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      bcnt_q <= bcnt_d;
      qnz_q  <= qnz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.qnz   = qnz_q;
  assign stat_o.digit = rem_q;

endmodule

// ----- rtl/itrd_digit_buf.sv -----
// Digit buffer: one write port, one read port with registered read data.
// Holds digits least significant first for reversed readout. No package use.
module itrd_digit_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [3:0]    rdata_o
);

  logic [3:0] mem_q [DEPTH];
  logic [3:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/integer_to_radix_digits_unit.sv -----
// Top level: converts a signed integer to ASCII text in radix 2..16.
// Uses itrd_pkg, itrd_divider and itrd_digit_buf.
//
// Usage:
//   Input: drive value_i and raise start_i; the word is taken at a rising
//   edge with start_i high and busy_o low. busy_o stays high until the
//   last character has been shown.
//   Output: each character appears on character_o for one cycle with
//   valid_o high, most significant first; a leading '-' marks a negative
//   value and last_o flags the final character. The receiver cannot stall.
//   Config: cfg_we_i writes cfg_wdata_i into the radix register (reset 10).
//   Values below 2 act as 2, above 16 as 16. Write only while idle.
// Timing: each digit costs one serial division pass through the
//   bit-serial divider. Digits leave the buffer one per cycle through its
//   registered read port.
// Reset: asynchronous, clears the sequencer and restores radix 10.
module integer_to_radix_digits_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          cfg_we_i,
  input  logic [4:0]                    cfg_wdata_i,
  output logic                          valid_o,
  output logic [6:0]                    character_o,
  output logic                          last_o
);
  import itrd_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int AW    = $clog2(MAX_DIGITS);

  itrd_state_e state_q, state_d;

  logic [4:0]       radix_q;
  logic [4:0]       radix_eff;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_m1;
  logic             neg_q, neg_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             more_digits;

  logic [VALUE_WIDTH-1:0] val_u;
  logic [VALUE_WIDTH-1:0] mag;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  logic          buf_we;
  logic          buf_re;
  logic [AW-1:0] buf_raddr;
  logic [3:0]    buf_rdata;

  assign radix_eff = effective_radix(radix_q);
  assign val_u     = value_i;
  assign mag       = val_u[VALUE_WIDTH-1] ? (~val_u + VALUE_WIDTH'(1)) : val_u;
  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign buf_raddr = cnt_m1[AW-1:0];
  // another pass only while the quotient is nonzero and the buffer has room
  assign more_digits = div_stat.qnz && (cnt_q != CNT_W'(MAX_DIGITS - 1));

  itrd_divider #(
    .W (VALUE_WIDTH)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .mag_i   (mag),
    .radix_i (radix_eff),
    .stat_o  (div_stat)
  );

  itrd_digit_buf #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_digit_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (div_stat.digit),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done && !more_digits) begin
          state_d = neg_q ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        state_d = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (pend_q && pend_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    div_ctrl    = '0;
    busy_o      = 1'b1;
    valid_o     = 1'b0;
    character_o = digit_char(buf_rdata);
    last_o      = 1'b0;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    buf_we      = 1'b0;
    buf_re      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          div_ctrl.load  = 1'b1;
          div_ctrl.start = 1'b1;
          cnt_d          = '0;
          neg_d          = val_u[VALUE_WIDTH-1];
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          if (more_digits) begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        valid_o     = 1'b1;
        character_o = CH_MINUS;
      end
      ST_DIGITS: begin
        valid_o = pend_q;
        last_o  = pend_last_q;
        // walk the buffer downward, most significant digit first
        if (cnt_q != '0) begin
          buf_re      = 1'b1;
          cnt_d       = cnt_m1;
          pend_d      = 1'b1;
          pend_last_d = (cnt_q == CNT_W'(1));
        end
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- rtl/itrd_checker.sv -----
// Port-level checker for integer_to_radix_digits_unit, bound to the top.
// Uses itrd_pkg for the sign character.
module itrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic [6:0] character_o,
  input logic       last_o
);
  import itrd_pkg::*;

  // a character only appears while a word is in progress
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("character shown while idle");

  // an accepted word makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy did not rise after accept");

  // the final character releases the unit
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !busy_o)
    else $error("still busy after last character");

  // the sign is never the whole text
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (character_o == CH_MINUS)) |-> !last_o)
    else $error("sign flagged as last character");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .valid_o     (valid_o),
  .character_o (character_o),
  .last_o      (last_o)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for integer_to_radix_digits_unit.
// Depends on itrd_pkg and the unit RTL; predicts every character and checks it.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itrd_pkg::*;

  typedef struct packed {
    logic [6:0] code;
    logic       is_last;
  } text_char_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] value_i;
  logic               cfg_we_i;
  logic [4:0]         cfg_wdata_i;
  logic               valid_o;
  logic [6:0]         character_o;
  logic               last_o;

  text_char_t  expected_chars[$];
  logic [4:0]  radix_reg;
  int          mismatch_count;

  integer_to_radix_digits_unit #(
    .VALUE_WIDTH(32),
    .MAX_DIGITS (32)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #15_000_000;
    $display("integer_to_radix_digits_unit regression: fail");
    $finish;
  end

  // Expected text of one value in the given raw radix, sign first.
  function automatic void predict_text(input logic signed [31:0] v, input logic [4:0] raw);
    logic [4:0]  base;
    logic [31:0] mag;
    logic [3:0]  digits [32];
    logic [3:0]  d;
    text_char_t  c;
    int          count;
    base = raw;
    if (raw < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (raw > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    mag = v;
    // two's complement negate, exact for the most negative value
    if (v[31]) begin
      mag = ~mag + 32'd1;
    end
    count = 0;
    if (mag == 32'd0) begin
      digits[0] = 4'd0;
      count = 1;
    end
    while (mag != 32'd0) begin
      digits[count] = 4'(mag % {27'd0, base});
      mag = mag / {27'd0, base};
      count++;
    end
    if (v[31]) begin
      c.code = CH_MINUS;
      c.is_last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = count - 1; i >= 0; i--) begin
      d = digits[i];
      if (d < DECIMAL_LIMIT) begin
        c.code = CH_ZERO + {3'b000, d};
      end else begin
        c.code = CH_LETTER + {3'b000, d - DECIMAL_LIMIT};
      end
      c.is_last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string what, input text_char_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected char 0x%02h last %b, got char 0x%02h last %b",
               $realtime, what, want.code, want.is_last, character_o, last_o);
    end
  endtask

  always @(posedge clk_i) begin : check_chars
    text_char_t want;
    if (rst_ni && valid_o) begin
      if (expected_chars.size() == 0) begin
        want = 'x;
        report_mismatch("unexpected character", want);
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.code || last_o !== want.is_last) begin
          report_mismatch("character mismatch", want);
        end
      end
    end
  end

  // Mostly back to back, sometimes short pauses, rarely long ones.
  function automatic int idle_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) begin
      return 0;
    end else if (p < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 50);
      2: v = -$urandom_range(1, 50);
      3: v = 32'h7fff_ffff - $urandom_range(0, 3);
      4: v = 32'h8000_0000 + $urandom_range(0, 3);
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Hold start until the word is taken, then predict its text.
  task automatic send_word(input logic signed [31:0] v, input int gap);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    start_i = 1'b1;
    value_i = v;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    predict_text(v, radix_reg);
    @(negedge clk_i);
    start_i = 1'b0;
    value_i = $urandom;
  endtask

  task automatic wait_idle();
    while (expected_chars.size() != 0 || busy_o) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_radix(input logic [4:0] r);
    wait_idle();
    repeat (idle_cycles()) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = r;
    radix_reg = r;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_reset_radix();
    send_word(32'sd0, 0);
    send_word(32'sd1, 0);
    send_word(-32'sd1, 2);
    send_word(32'sh7fff_ffff, 0);
    send_word(32'sh8000_0000, 0);
    send_word(-32'sd987, 1);
  endtask

  task automatic test_radix_extremes();
    write_radix(5'd2);
    send_word(32'sh8000_0000, 0);
    send_word(32'sh7fff_ffff, 0);
    send_word(32'sd0, 3);
    write_radix(5'd16);
    send_word(32'sh8000_0000, 0);
    send_word(32'sh7fff_ffff, 0);
    send_word(-32'sh00ab_cdef, 0);
    send_word(32'sh1234_5678, 1);
  endtask

  // Out-of-range radix values clamp to the nearest legal base.
  task automatic test_radix_clamping();
    write_radix(5'd0);
    send_word(32'sd5, 0);
    write_radix(5'd1);
    send_word(-32'sd6, 0);
    write_radix(5'd17);
    send_word(32'sh0000_fade, 0);
    write_radix(5'd31);
    send_word(-32'sh0bad_cafe, 0);
  endtask

  task automatic test_random_words();
    logic [4:0] r;
    bit         idle_on;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: r = 5'd2;
        1: r = 5'd16;
        2: r = 5'd10;
        default: r = 5'($urandom_range(0, 31));
      endcase
      write_radix(r);
      idle_on = (phase % 3 != 0);
      for (int n = 0; n < 15; n++) begin
        send_word(random_value(), idle_on ? idle_cycles() : 0);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    radix_reg = RADIX_RESET;
    mismatch_count = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_radix();
    test_radix_extremes();
    test_radix_clamping();
    test_random_words();

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      mismatch_count += expected_chars.size();
      $display("%0d expected characters never arrived", expected_chars.size());
    end
    if (mismatch_count == 0) begin
      $display("integer_to_radix_digits_unit regression: pass");
    end else begin
      $display("integer_to_radix_digits_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/itrd_pkg.sv
rtl/itrd_divider.sv
rtl/itrd_digit_buf.sv
rtl/integer_to_radix_digits_unit.sv
rtl/itrd_checker.sv
tb/testbench.sv
